/* hw/rtl/bsm_pkg.sv */
// Shared types and constants for the bounding sphere merge block.
// Used by bsm_front, bsm_queue, bsm_back and bounding_sphere_merge; no dependencies.
package bsm_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int RAD_WIDTH   = COORD_WIDTH - 1;
  localparam int BOUND_WIDTH = COORD_WIDTH + 2;
  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int ACC_WIDTH   = 2 * COORD_WIDTH + 2;
  localparam int REM_WIDTH   = COORD_WIDTH + 3;
  localparam int STEP_WIDTH  = $clog2(COORD_WIDTH + 1);
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_WIDTH = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_WIDTH = $clog2(Q_DEPTH + 1);
  localparam int NUM_AXES    = 3;
  localparam int NUM_SQ      = NUM_AXES;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [BOUND_WIDTH-1:0] bound_t;
  typedef logic [RAD_WIDTH-1:0]          radius_t;

  localparam bound_t BOUND_MAX  = {1'b0, {(BOUND_WIDTH-1){1'b1}}};
  localparam bound_t BOUND_MIN  = {1'b1, {(BOUND_WIDTH-1){1'b0}}};
  localparam bound_t COORD_SMAX = {{3{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam bound_t COORD_SMIN = {{3{1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                        single;
    coord_t                      x;
    coord_t                      y;
    coord_t                      z;
    radius_t                     radius;
    logic [NUM_AXES-1:0][BOUND_WIDTH-1:0] low;
    logic [NUM_AXES-1:0][BOUND_WIDTH-1:0] high;
  } bsm_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } bsm_q_status_t;

  typedef struct packed {
    coord_t                 x;
    coord_t                 y;
    coord_t                 z;
    logic [COORD_WIDTH-1:0] radius;
    logic                   clipped;
  } bsm_result_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MID  = 5'b00010,
    ST_SQ   = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DONE = 5'b10000
  } bsm_state_t;

endpackage

/* hw/rtl/bsm_front.sv */
// Front part: accepts spheres and keeps the six running box bounds.
// Pushes one run record to the queue on the last sphere; depends on bsm_pkg.
module bsm_front import bsm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  coord_t        in_x,
  input  coord_t        in_y,
  input  coord_t        in_z,
  input  radius_t       in_radius,
  input  logic          in_last,
  input  logic          in_push,
  output logic          in_full,
  input  bsm_q_status_t q_status,
  output logic          q_push,
  output bsm_entry_t    q_data
);

  bound_t low_r  [NUM_AXES];
  bound_t high_r [NUM_AXES];
  bound_t low_nxt  [NUM_AXES];
  bound_t high_nxt [NUM_AXES];
  logic   seen_r;
  logic   accept;

  assign in_full = q_status.full;
  assign accept  = in_push & ~q_status.full;
  assign q_push  = accept & in_last;

  always_comb begin
    coord_t cen [NUM_AXES];
    bound_t cext;
    bound_t rext;
    bound_t lo_c;
    bound_t hi_c;
    cen[0] = in_x;
    cen[1] = in_y;
    cen[2] = in_z;
    rext   = {3'b000, in_radius};
    for (int i = 0; i < NUM_AXES; i++) begin
      cext = {{2{cen[i][COORD_WIDTH-1]}}, cen[i]};
      lo_c = cext - rext;
      hi_c = cext + rext;
      low_nxt[i]  = (lo_c < low_r[i])  ? lo_c : low_r[i];
      high_nxt[i] = (hi_c > high_r[i]) ? hi_c : high_r[i];
    end
  end

  always_comb begin
    q_data.single = ~seen_r;
    q_data.x      = in_x;
    q_data.y      = in_y;
    q_data.z      = in_z;
    q_data.radius = in_radius;
    for (int i = 0; i < NUM_AXES; i++) begin
      q_data.low[i]  = low_nxt[i];
      q_data.high[i] = high_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        low_r[i]  <= BOUND_MAX;
        high_r[i] <= BOUND_MIN;
      end
      seen_r <= 1'b0;
    end else if (accept) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        low_r[i]  <= low_nxt[i];
        high_r[i] <= high_nxt[i];
      end
      seen_r <= 1'b1;
    end
  end

endmodule

/* hw/rtl/bsm_queue.sv */
// Short queue of run records between the front and back parts.
// Depth set by Q_DEPTH; depends on bsm_pkg.
module bsm_queue import bsm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsm_entry_t    wr_data,
  input  logic          pop,
  output bsm_entry_t    rd_data,
  output bsm_q_status_t status
);

  bsm_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_WIDTH-1:0] wr_ptr_r;
  logic [Q_PTR_WIDTH-1:0] rd_ptr_r;
  logic [Q_CNT_WIDTH-1:0] cnt_r;
  logic                   do_push;
  logic                   do_pop;

  assign status.full  = (cnt_r == Q_CNT_WIDTH'(Q_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push & ~status.full;
  assign do_pop       = pop & ~status.empty;
  assign rd_data      = mem_r[rd_ptr_r];

  function automatic logic [Q_PTR_WIDTH-1:0] ptr_inc(input logic [Q_PTR_WIDTH-1:0] p);
    if (p == Q_PTR_WIDTH'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/bsm_back.sv */
// Back part: midpoint, squared distance with one shared multiplier, bit-serial root.
// Holds the result until it is popped; depends on bsm_pkg.
module bsm_back import bsm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  bsm_entry_t    q_data,
  input  bsm_q_status_t q_status,
  output logic          q_pop,
  output bsm_result_t   result,
  output logic          out_empty,
  input  logic          out_pop
);

  bsm_state_t             state_r, state_nxt;
  bsm_entry_t             ent_r, ent_nxt;
  logic [COORD_WIDTH-1:0] d_r [NUM_SQ];
  logic [COORD_WIDTH-1:0] d_nxt [NUM_SQ];
  logic [SQ_WIDTH-1:0]    prod_r, prod_nxt;
  logic [ACC_WIDTH-1:0]   acc_r, acc_nxt;
  logic [STEP_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic [SQ_WIDTH-1:0]    n_r, n_nxt;
  logic [REM_WIDTH-1:0]   rem_r, rem_nxt;
  logic [COORD_WIDTH-1:0] root_r, root_nxt;
  bsm_result_t            res_r, res_nxt;

  assign result    = res_r;
  assign out_empty = (state_r != ST_DONE);

  always_comb begin
    logic [BOUND_WIDTH:0]   sum;
    bound_t                 mid;
    bound_t                 lo;
    bound_t                 diff;
    coord_t                 sat [NUM_AXES];
    logic                   clip;
    logic [REM_WIDTH-1:0]   rem_sh;
    logic [REM_WIDTH-1:0]   trial;
    state_nxt = state_r;
    ent_nxt   = ent_r;
    d_nxt     = d_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    res_nxt   = res_r;
    q_pop     = 1'b0;
    clip      = 1'b0;
    sum       = '0;
    mid       = '0;
    lo        = '0;
    diff      = '0;
    rem_sh    = '0;
    trial     = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      sat[i] = '0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_data;
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        if (ent_r.single) begin
          res_nxt.x       = ent_r.x;
          res_nxt.y       = ent_r.y;
          res_nxt.z       = ent_r.z;
          res_nxt.radius  = {1'b0, ent_r.radius};
          res_nxt.clipped = 1'b0;
          state_nxt       = ST_DONE;
        end else begin
          for (int i = 0; i < NUM_AXES; i++) begin
            lo   = ent_r.low[i];
            sum  = {lo[BOUND_WIDTH-1], lo}
                 + {ent_r.high[i][BOUND_WIDTH-1], ent_r.high[i]};
            mid  = sum[BOUND_WIDTH:1];
            diff = mid - lo;
            d_nxt[i] = diff[COORD_WIDTH-1:0];
            if (mid > COORD_SMAX) begin
              sat[i] = COORD_SMAX[COORD_WIDTH-1:0];
              clip   = 1'b1;
            end else if (mid < COORD_SMIN) begin
              sat[i] = COORD_SMIN[COORD_WIDTH-1:0];
              clip   = 1'b1;
            end else begin
              sat[i] = mid[COORD_WIDTH-1:0];
            end
          end
          res_nxt.x       = sat[0];
          res_nxt.y       = sat[1];
          res_nxt.z       = sat[2];
          res_nxt.clipped = clip;
          prod_nxt        = '0;
          acc_nxt         = '0;
          cnt_nxt         = '0;
          state_nxt       = ST_SQ;
        end
      end
      ST_SQ: begin
        acc_nxt = acc_r + ACC_WIDTH'(prod_r);
        if (cnt_r[1:0] != 2'(NUM_SQ)) begin
          prod_nxt = SQ_WIDTH'(d_r[cnt_r[1:0]]) * SQ_WIDTH'(d_r[cnt_r[1:0]]);
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          n_nxt    = acc_nxt[SQ_WIDTH-1:0];
          rem_nxt  = '0;
          root_nxt = '0;
          cnt_nxt  = '0;
          if (acc_nxt[ACC_WIDTH-1:SQ_WIDTH] != '0) begin
            res_nxt.radius  = '1;
            res_nxt.clipped = 1'b1;
            state_nxt       = ST_DONE;
          end else begin
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        rem_sh = {rem_r[REM_WIDTH-3:0], n_r[SQ_WIDTH-1:SQ_WIDTH-2]};
        trial  = {1'b0, root_r, 2'b01};
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[COORD_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[COORD_WIDTH-2:0], 1'b0};
        end
        n_nxt   = {n_r[SQ_WIDTH-3:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_WIDTH'(COORD_WIDTH - 1)) begin
          res_nxt.radius = root_nxt;
          state_nxt      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    d_r    <= d_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    res_r  <= res_nxt;
  end

endmodule

/* hw/rtl/bounding_sphere_merge.sv */
// Top level of the bounding sphere merge block: front, run queue and back.
// Depends on bsm_pkg, bsm_front, bsm_queue and bsm_back.
//
// Spheres (signed Q15.8 centre, unsigned Q15.8 radius) are taken one per cycle
// while in_full is low; the front folds each into the running box in the same
// cycle. A sphere with in_last high closes the run and queues it (two runs deep).
// The back turns each run into one enclosing sphere: a run of a single sphere
// passes through from the queue without the multiplier or root; any other run
// takes three passes of one shared 24x24 multiplier and a 24-step bit-serial
// square root, plus the transfer out. A run whose squared distance overflows
// skips the root. out_clipped is high when any output field saturated. The
// result stays on the out_ ports until popped.
module bounding_sphere_merge import bsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  coord_t                 in_x,
  input  coord_t                 in_y,
  input  coord_t                 in_z,
  input  radius_t                in_radius,
  input  logic                   in_last,
  input  logic                   in_push,
  output logic                   in_full,
  output coord_t                 out_x,
  output coord_t                 out_y,
  output coord_t                 out_z,
  output logic [COORD_WIDTH-1:0] out_radius,
  output logic                   out_clipped,
  output logic                   out_empty,
  input  logic                   out_pop
);

  bsm_q_status_t q_status;
  bsm_entry_t    q_wr_data;
  bsm_entry_t    q_rd_data;
  logic          q_push;
  logic          q_pop;
  bsm_result_t   result;

  bsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_radius (in_radius),
    .in_last   (in_last),
    .in_push   (in_push),
    .in_full   (in_full),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  bsm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  bsm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rd_data),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .result    (result),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

  assign out_x       = result.x;
  assign out_y       = result.y;
  assign out_z       = result.z;
  assign out_radius  = result.radius;
  assign out_clipped = result.clipped;

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for bounding_sphere_merge: runs of spheres in, one enclosing sphere out.
// Predicts each result from a running box per axis; needs bsm_pkg and the block's RTL.
// Directed corner runs first, then three random phases with shifting push/pop idling.
module testbench;
  import bsm_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam coord_t  C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t  C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam radius_t R_MAX = '1;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    radius_t radius;
    logic    last;
  } sphere_t;

  typedef enum {SPREAD_NEAR, SPREAD_FULL, SPREAD_EDGE} spread_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  coord_t                 in_x = '0;
  coord_t                 in_y = '0;
  coord_t                 in_z = '0;
  radius_t                in_radius = '0;
  logic                   in_last = 1'b0;
  logic                   in_push = 1'b0;
  logic                   in_full;
  coord_t                 out_x;
  coord_t                 out_y;
  coord_t                 out_z;
  logic [COORD_WIDTH-1:0] out_radius;
  logic                   out_clipped;
  logic                   out_empty;
  logic                   out_pop = 1'b0;

  sphere_t     pending_spheres [$];
  bsm_result_t enclosing_q [$];
  bound_t      box_lo [NUM_AXES];
  bound_t      box_hi [NUM_AXES];
  logic        run_open;
  int          send_idle_pct = 12;
  int          recv_idle_pct = 85;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  logic        stalled = 1'b0;

  bounding_sphere_merge DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_z        (in_z),
    .in_radius   (in_radius),
    .in_last     (in_last),
    .in_push     (in_push),
    .in_full     (in_full),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_radius  (out_radius),
    .out_clipped (out_clipped),
    .out_empty   (out_empty),
    .out_pop     (out_pop)
  );

  always #5 clk = ~clk;

  task automatic clear_box();
    for (int a = 0; a < NUM_AXES; a++) begin
      box_lo[a] = BOUND_MAX;
      box_hi[a] = BOUND_MIN;
    end
    run_open = 1'b0;
  endtask

  function automatic logic [COORD_WIDTH-1:0] int_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = COORD_WIDTH - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root[COORD_WIDTH-1:0];
  endfunction

  task automatic fold_sphere(input sphere_t s);
    longint          centre [NUM_AXES];
    coord_t          mid_sat [NUM_AXES];
    longint          rad;
    longint          mid;
    longint          span;
    longint unsigned dist_sq;
    logic            fits;
    bsm_result_t     res;
    centre[0] = longint'(s.x);
    centre[1] = longint'(s.y);
    centre[2] = longint'(s.z);
    rad = longint'(s.radius);
    for (int a = 0; a < NUM_AXES; a++) begin
      if (centre[a] - rad < box_lo[a]) box_lo[a] = bound_t'(centre[a] - rad);
      if (centre[a] + rad > box_hi[a]) box_hi[a] = bound_t'(centre[a] + rad);
    end
    if (!s.last) begin
      run_open = 1'b1;
      return;
    end
    res.clipped = 1'b0;
    if (!run_open) begin
      res.x      = s.x;
      res.y      = s.y;
      res.z      = s.z;
      res.radius = {1'b0, s.radius};
    end else begin
      dist_sq = 0;
      fits    = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        mid  = (longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1;
        span = mid - longint'(box_lo[a]);
        if (span >= (longint'(1) << COORD_WIDTH)) begin
          fits = 1'b0;
        end else begin
          dist_sq += span * span;
          if (dist_sq >= (64'd1 << SQ_WIDTH)) fits = 1'b0;
        end
        if (mid > COORD_SMAX) begin
          mid = longint'(COORD_SMAX);
          res.clipped = 1'b1;
        end
        if (mid < COORD_SMIN) begin
          mid = longint'(COORD_SMIN);
          res.clipped = 1'b1;
        end
        mid_sat[a] = coord_t'(mid);
      end
      res.x = mid_sat[0];
      res.y = mid_sat[1];
      res.z = mid_sat[2];
      if (fits) begin
        res.radius = int_root(dist_sq);
      end else begin
        res.radius  = '1;
        res.clipped = 1'b1;
      end
    end
    enclosing_q.push_back(res);
    clear_box();
  endtask

  function automatic coord_t pick_coord(input spread_t sp);
    case (sp)
      SPREAD_NEAR: return coord_t'(int'($urandom_range(8191)) - 4096);
      SPREAD_FULL: return coord_t'($urandom);
      default: begin
        case ($urandom_range(5))
          0: return C_MAX;
          1: return C_MIN;
          2: return coord_t'(C_MAX - 1);
          3: return coord_t'(C_MIN + 1);
          4: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic radius_t pick_radius(input spread_t sp);
    case (sp)
      SPREAD_NEAR: return radius_t'($urandom_range(2047));
      SPREAD_FULL: return radius_t'($urandom);
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return R_MAX;
          default: return radius_t'(1);
        endcase
      end
    endcase
  endfunction

  task automatic push_sphere(input coord_t x, input coord_t y, input coord_t z,
                             input radius_t r, input logic last);
    pending_spheres.push_back(sphere_t'{x, y, z, r, last});
  endtask

  task automatic queue_random(input int count);
    int      queued;
    int      len;
    int      roll;
    spread_t sp;
    queued = 0;
    while (queued < count) begin
      len  = ($urandom_range(99) < 15) ? 1 : int'($urandom_range(8, 2));
      roll = $urandom_range(99);
      if (roll < 50) sp = SPREAD_NEAR;
      else if (roll < 80) sp = SPREAD_FULL;
      else sp = SPREAD_EDGE;
      for (int i = 0; i < len; i++) begin
        push_sphere(pick_coord(sp), pick_coord(sp), pick_coord(sp), pick_radius(sp),
                    i == len - 1);
      end
      queued += len;
    end
  endtask

  task automatic wait_quiet();
    while (!stalled && (pending_spheres.size() != 0 || in_push || enclosing_q.size() != 0))
      @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [COORD_WIDTH-1:0] want,
                             input logic [COORD_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : drive_spheres
    sphere_t next;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (in_push) fold_sphere(sphere_t'{in_x, in_y, in_z, in_radius, in_last});
      if (pending_spheres.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next = pending_spheres.pop_front();
        in_x      <= next.x;
        in_y      <= next.y;
        in_z      <= next.z;
        in_radius <= next.radius;
        in_last   <= next.last;
        in_push   <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    bsm_result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (enclosing_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h %h %h %h %b",
                   $time, out_x, out_y, out_z, out_radius, out_clipped);
          mismatches++;
        end else begin
          want = enclosing_q.pop_front();
          check_field("x", want.x, out_x);
          check_field("y", want.y, out_y);
          check_field("z", want.z, out_z);
          check_field("radius", want.radius, out_radius);
          check_field("clipped", COORD_WIDTH'(want.clipped), COORD_WIDTH'(out_clipped));
        end
      end
      out_pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) stalled <= 1'b1;
  end

  initial begin
    clear_box();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_sphere(C_MAX, C_MAX, C_MAX, R_MAX, 1'b1);
    push_sphere(C_MIN, C_MIN, C_MIN, '0, 1'b1);
    push_sphere('0, '1, coord_t'(1), radius_t'(1), 1'b1);
    push_sphere(C_MAX, C_MIN, '0, R_MAX, 1'b0);
    push_sphere(C_MIN, C_MAX, '0, R_MAX, 1'b1);
    push_sphere(coord_t'(-3), '0, coord_t'(5), '0, 1'b0);
    push_sphere('0, coord_t'(-3), coord_t'(6), '0, 1'b1);
    push_sphere(C_MAX, C_MAX, C_MAX, '0, 1'b0);
    push_sphere(C_MAX, C_MAX, C_MAX, R_MAX, 1'b1);
    push_sphere(C_MIN, C_MIN, C_MIN, R_MAX, 1'b0);
    push_sphere(C_MIN, C_MIN, C_MIN, '0, 1'b1);
    push_sphere(coord_t'(100), coord_t'(200), coord_t'(300), radius_t'(50), 1'b0);
    push_sphere(coord_t'(-100), coord_t'(-200), coord_t'(-300), radius_t'(60), 1'b0);
    push_sphere(coord_t'(7), coord_t'(8), coord_t'(9), '0, 1'b1);
    push_sphere('0, '0, '0, R_MAX, 1'b0);
    push_sphere('0, '0, '0, '0, 1'b1);
    push_sphere(C_MAX, '0, '0, '0, 1'b0);
    push_sphere('0, C_MIN, '0, '0, 1'b0);
    push_sphere('0, '0, C_MAX, '0, 1'b0);
    push_sphere('0, '0, '0, R_MAX, 1'b1);
    wait_quiet();

    queue_random(480);
    wait_quiet();
    send_idle_pct = 85;
    recv_idle_pct = 12;
    queue_random(480);
    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(470);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!stalled && mismatches == 0 && enclosing_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_front.sv
hw/rtl/bsm_queue.sv
hw/rtl/bsm_back.sv
hw/rtl/bounding_sphere_merge.sv
tb/sv/testbench.sv
